@@ src/etf_pkg.sv @@
// Shared types, constants and saturation helper for the escape-time fractal iterator.
package etf_pkg;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 1024;

   localparam int PIX_W     = 10;
   localparam int ITER_W    = 10;
   localparam int MODE_W    = 2;
   localparam int Q_W       = 32;
   localparam int FRAC_W    = 24;
   localparam int WIDE_W    = 2 * Q_W;
   localparam int CSR_IDX_W = 3;

   localparam int HALF_X = SCREEN_WIDTH / 2;
   localparam int HALF_Y = SCREEN_HEIGHT / 2;

   localparam int AXIS_BITS_X = (PIX_W > $clog2(SCREEN_WIDTH)) ? PIX_W : $clog2(SCREEN_WIDTH);
   localparam int AXIS_BITS_Y = (PIX_W > $clog2(SCREEN_HEIGHT)) ? PIX_W : $clog2(SCREEN_HEIGHT);
   localparam int D_W = ((AXIS_BITS_X > AXIS_BITS_Y) ? AXIS_BITS_X : AXIS_BITS_Y) + 1;
   localparam int PROD_W = D_W + Q_W;

   localparam logic [WIDE_W-1:0] FOUR_WIDE = WIDE_W'(4) << (2 * FRAC_W);
   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE = (WIDE_W'(1) << (Q_W - 1)) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE = ~Q_MAX_WIDE;

   localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_MAX_ITER = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5,
      CSR_JULIA_RE = 3'd6,
      CSR_JULIA_IM = 3'd7
   } csr_index_type;

   localparam logic [MODE_W-1:0]     RST_MODE     = MODE_MANDEL;
   localparam logic [ITER_W-1:0]     RST_MAX_ITER = 10'd150;
   localparam logic signed [Q_W-1:0] RST_STEP     = 32'sd163840;
   localparam logic signed [Q_W-1:0] RST_OFFSET   = 32'sd1677722;
   localparam logic signed [Q_W-1:0] RST_JULIA_RE = -32'sd11744051;
   localparam logic signed [Q_W-1:0] RST_JULIA_IM = 32'sd4529848;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [ITER_W-1:0]     max_iter;
      logic signed [Q_W-1:0] step_x;
      logic signed [Q_W-1:0] step_y;
      logic signed [Q_W-1:0] offset_x;
      logic signed [Q_W-1:0] offset_y;
      logic signed [Q_W-1:0] julia_re;
      logic signed [Q_W-1:0] julia_im;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic map_mul;
      logic map_add;
      logic iter_mul;
      logic iter_test;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic out_free;
   } status_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      if (v > Q_MAX_WIDE) begin
         r = Q_MAX_WIDE;
      end else if (v < Q_MIN_WIDE) begin
         r = Q_MIN_WIDE;
      end else begin
         r = v;
      end
      return $signed(r[Q_W-1:0]);
   endfunction

endpackage

@@ src/etf_csr.sv @@
// Configuration register bank of the escape-time fractal iterator.
module etf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [etf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etf_pkg::Q_W-1:0]       csr_wr_data,
   output etf_pkg::cfg_type              cfg
);
   import etf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:     cfg_in.mode     = csr_wr_data[MODE_W-1:0];
            CSR_MAX_ITER: cfg_in.max_iter = csr_wr_data[ITER_W-1:0];
            CSR_STEP_X:   cfg_in.step_x   = $signed(csr_wr_data);
            CSR_STEP_Y:   cfg_in.step_y   = $signed(csr_wr_data);
            CSR_OFFSET_X: cfg_in.offset_x = $signed(csr_wr_data);
            CSR_OFFSET_Y: cfg_in.offset_y = $signed(csr_wr_data);
            CSR_JULIA_RE: cfg_in.julia_re = $signed(csr_wr_data);
            CSR_JULIA_IM: cfg_in.julia_im = $signed(csr_wr_data);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= RST_MODE;
         cfg_ff.max_iter <= RST_MAX_ITER;
         cfg_ff.step_x   <= RST_STEP;
         cfg_ff.step_y   <= RST_STEP;
         cfg_ff.offset_x <= RST_OFFSET;
         cfg_ff.offset_y <= RST_OFFSET;
         cfg_ff.julia_re <= RST_JULIA_RE;
         cfg_ff.julia_im <= RST_JULIA_IM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/etf_ctrl.sv @@
// Sequencing state machine of the escape-time fractal iterator.
module etf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  etf_pkg::status_type status,
   output etf_pkg::cmd_type    cmd
);
   import etf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_MAP_MUL = 6'b000010,
      ST_MAP_ADD = 6'b000100,
      ST_MUL     = 6'b001000,
      ST_TEST    = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in    = ST_MAP_ADD;
         end
         ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.iter_mul = 1'b1;
            state_in     = ST_TEST;
         end
         ST_TEST: begin
            cmd.iter_test = 1'b1;
            state_in      = status.stop ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/etf_dpath.sv @@
// Coordinate mapping, z-update datapath and response register of the fractal iterator.
module etf_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  etf_pkg::cfg_type            cfg,
   input  etf_pkg::cmd_type            cmd,
   output etf_pkg::status_type         status,
   input  logic [etf_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic [etf_pkg::PIX_W-1:0]   req_pixel_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [etf_pkg::PIX_W-1:0]   rsp_out_x,
   output logic [etf_pkg::PIX_W-1:0]   rsp_out_y,
   output logic [etf_pkg::ITER_W-1:0]  rsp_iterations,
   output logic                        rsp_escaped
);
   import etf_pkg::*;

   logic [PIX_W-1:0]           px_ff, px_in, py_ff, py_in;
   logic signed [PROD_W-1:0]   mx_ff, mx_in, my_ff, my_in;
   logic signed [Q_W-1:0]      zr_ff, zr_in, zi_ff, zi_in;
   logic signed [Q_W-1:0]      cr_ff, cr_in, ci_ff, ci_in;
   logic [ITER_W-1:0]          n_ff, n_in;
   logic signed [WIDE_W-1:0]   p_rr_ff, p_rr_in, p_ii_ff, p_ii_in, p_ri_ff, p_ri_in;
   logic                       esc_ff, esc_in;
   logic [PIX_W-1:0]           out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [ITER_W-1:0]          out_n_ff, out_n_in;
   logic                       out_esc_ff, out_esc_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [D_W-1:0]      dx, dy;
   logic signed [PROD_W-1:0]   prod_x, prod_y;
   logic signed [WIDE_W-1:0]   prod_rr, prod_ii, prod_ri;
   logic signed [Q_W-1:0]      pr, pi;
   logic signed [WIDE_W-1:0]   sq, cross_abs;
   logic signed [Q_W-1:0]      nr, ni;
   logic [WIDE_W-1:0]          mag;
   logic                       escape;
   logic                       julia;
   logic                       ship;

   always_comb begin
      julia = (cfg.mode == MODE_JULIA);
      ship  = (cfg.mode == MODE_SHIP);

      dx = $signed(D_W'(px_ff)) - $signed(D_W'(HALF_X));
      dy = $signed(D_W'(py_ff)) - $signed(D_W'(HALF_Y));
      prod_x  = dx * cfg.step_x;
      prod_y  = dy * cfg.step_y;
      prod_rr = zr_ff * zr_ff;
      prod_ii = zi_ff * zi_ff;
      prod_ri = zr_ff * zi_ff;
      pr = sat_q(WIDE_W'(sat_q(WIDE_W'(mx_ff))) + WIDE_W'(cfg.offset_x));
      pi = sat_q(WIDE_W'(sat_q(WIDE_W'(my_ff))) + WIDE_W'(cfg.offset_y));

      sq        = p_rr_ff - p_ii_ff;
      cross_abs = (ship && (p_ri_ff < 0)) ? -p_ri_ff : p_ri_ff;
      nr        = sat_q((sq >>> FRAC_W) + WIDE_W'(cr_ff));
      ni        = sat_q((cross_abs >>> (FRAC_W - 1)) + WIDE_W'(ci_ff));
      mag       = $unsigned(p_rr_ff) + $unsigned(p_ii_ff);
      escape    = (mag > FOUR_WIDE);

      status.stop     = escape || (n_ff == cfg.max_iter);
      status.out_free = !rsp_valid_ff || rsp_ready;

      px_in      = cmd.capture ? req_pixel_x : px_ff;
      py_in      = cmd.capture ? req_pixel_y : py_ff;
      mx_in      = cmd.map_mul ? prod_x : mx_ff;
      my_in      = cmd.map_mul ? prod_y : my_ff;
      p_rr_in    = cmd.iter_mul ? prod_rr : p_rr_ff;
      p_ii_in    = cmd.iter_mul ? prod_ii : p_ii_ff;
      p_ri_in    = cmd.iter_mul ? prod_ri : p_ri_ff;
      esc_in     = cmd.iter_test ? escape : esc_ff;

      zr_in = zr_ff;
      zi_in = zi_ff;
      cr_in = cr_ff;
      ci_in = ci_ff;
      n_in  = n_ff;
      if (cmd.map_add) begin
         zr_in = julia ? pr : '0;
         zi_in = julia ? pi : '0;
         cr_in = julia ? cfg.julia_re : pr;
         ci_in = julia ? cfg.julia_im : pi;
         n_in  = '0;
      end else if (cmd.iter_test && !status.stop) begin
         zr_in = nr;
         zi_in = ni;
         n_in  = n_ff + ITER_W'(1);
      end

      out_x_in   = cmd.emit ? px_ff  : out_x_ff;
      out_y_in   = cmd.emit ? py_ff  : out_y_ff;
      out_n_in   = cmd.emit ? n_ff   : out_n_ff;
      out_esc_in = cmd.emit ? esc_ff : out_esc_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      py_ff      <= py_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      n_ff       <= n_in;
      p_rr_ff    <= p_rr_in;
      p_ii_ff    <= p_ii_in;
      p_ri_ff    <= p_ri_in;
      esc_ff     <= esc_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_n_ff   <= out_n_in;
      out_esc_ff <= out_esc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_iterations = out_n_ff;
   assign rsp_escaped    = out_esc_ff;

endmodule

@@ src/escape_time_fractal_iterator.sv @@
// Top level of the escape-time fractal iterator (Mandelbrot, Julia, burning ship).
//
// Requests carry one pixel (req_pixel_x, req_pixel_y) on a valid/ready channel.
// The pixel is mapped to a Q8.24 point with the step and offset registers, then
// iterated as z = z^2 + c until |z|^2 exceeds 4 or max_iter updates are done
// (burning ship takes the absolute value of the cross term). Responses return
// the pixel, the update count and the escape flag on a valid/ready channel.
// Registers are written through csr_wr_en/csr_index/csr_wr_data; the user
// writes them only while no request is in flight, the block does not enforce it.
// After a request is accepted the pixel is scaled by the step registers and the
// offsets are added; each update then does the three 32x32 products in one
// state and the escape test and the saturating z update in the following state.
// One request is in flight at a time; the next one is accepted as soon as the
// previous result sits in the response register.
// A stalled receiver holds the response; a finished pixel then waits in the
// last state until the response register frees up.
// Reset (synchronous) loads the register defaults, empties the response
// register and leaves the block ready for a request.
module escape_time_fractal_iterator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [etf_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [etf_pkg::PIX_W-1:0]     req_pixel_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [etf_pkg::PIX_W-1:0]     rsp_out_x,
   output logic [etf_pkg::PIX_W-1:0]     rsp_out_y,
   output logic [etf_pkg::ITER_W-1:0]    rsp_iterations,
   output logic                          rsp_escaped,
   input  logic                          csr_wr_en,
   input  logic [etf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etf_pkg::Q_W-1:0]       csr_wr_data
);
   import etf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   etf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   etf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   etf_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_iterations (rsp_iterations),
      .rsp_escaped    (rsp_escaped)
   );

endmodule

@@ src/etf_checker.sv @@
// Port-level assertions for the escape-time fractal iterator, bound to the top level.
module etf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [etf_pkg::PIX_W-1:0]     req_pixel_x,
   input logic [etf_pkg::PIX_W-1:0]     req_pixel_y,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [etf_pkg::PIX_W-1:0]     rsp_out_x,
   input logic [etf_pkg::PIX_W-1:0]     rsp_out_y,
   input logic [etf_pkg::ITER_W-1:0]    rsp_iterations,
   input logic                          rsp_escaped
);
   import etf_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
          && $stable(rsp_iterations) && $stable(rsp_escaped)))
      else $error("stalled response changed");

   // hold a waiting request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=>
         (req_valid && $stable(req_pixel_x) && $stable(req_pixel_y)))
      else $error("waiting request changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("response appeared too early");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind escape_time_fractal_iterator etf_checker u_etf_checker (.*);

@@ bench/escape_time_fractal_iterator_tb.sv @@
// Self-checking bench for the escape-time fractal iterator: pixel requests in, predicted counts out.
`timescale 1ns / 1ps

module escape_time_fractal_iterator_tb;
   import etf_pkg::*;

   localparam int     CYCLE_LIMIT = 2000000;
   localparam int     Q_ONE       = 1 << FRAC_W;
   localparam longint Q_HI        = longint'(2147483647);
   localparam longint Q_LO        = -longint'(2147483647) - 1;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } pixel_req_t;

   typedef struct {
      logic [PIX_W-1:0]  x;
      logic [PIX_W-1:0]  y;
      logic [ITER_W-1:0] iters;
      logic              esc;
   } pixel_result_t;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_x = '0;
   logic [PIX_W-1:0]     req_pixel_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [PIX_W-1:0]     rsp_out_x;
   logic [PIX_W-1:0]     rsp_out_y;
   logic [ITER_W-1:0]    rsp_iterations;
   logic                 rsp_escaped;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [Q_W-1:0]       csr_wr_data = '0;

   escape_time_fractal_iterator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_iterations (rsp_iterations),
      .rsp_escaped    (rsp_escaped),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // local copy of the register file
   logic [MODE_W-1:0] set_mode  = RST_MODE;
   logic [ITER_W-1:0] set_limit = RST_MAX_ITER;
   int set_step_x = RST_STEP;
   int set_step_y = RST_STEP;
   int set_pan_x  = RST_OFFSET;
   int set_pan_y  = RST_OFFSET;
   int set_c_re   = RST_JULIA_RE;
   int set_c_im   = RST_JULIA_IM;

   pixel_req_t    pending_pixels[$];
   pixel_result_t pixel_outcomes[$];
   pixel_req_t    next_pixel;
   pixel_result_t want;

   int  n_sent = 0;
   int  n_recv = 0;
   logic req_taken = 1'b0;
   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  settings_count = 0;
   int  escaped_count = 0;
   int  capped_count = 0;
   int  launched = 0;
   int  send_gap = 0;
   int  send_calm = 0;
   int  ready_hold = 0;
   int  ready_calm = 0;
   bit  drain_hold = 1'b0;

   function automatic longint clamp_q(input longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   function automatic longint map_to_plane(input logic [PIX_W-1:0] pix, input int half,
                                           input int stride, input int pan);
      longint d;
      d = longint'(pix) - half;
      return clamp_q(clamp_q(d * stride) + pan);
   endfunction

   function automatic longint unsigned radius_sq(input longint re, input longint im);
      longint unsigned a;
      longint unsigned b;
      a = re * re;
      b = im * im;
      return a + b;
   endfunction

   function automatic pixel_result_t evaluate_pixel(input logic [PIX_W-1:0] px,
                                                    input logic [PIX_W-1:0] py);
      pixel_result_t res;
      longint pr, pim, zr, zi, cr, ci, sq, twice_re_im, nr, ni;
      int n;
      pr  = map_to_plane(px, HALF_X, set_step_x, set_pan_x);
      pim = map_to_plane(py, HALF_Y, set_step_y, set_pan_y);
      if (set_mode == MODE_JULIA) begin
         zr = pr;
         zi = pim;
         cr = set_c_re;
         ci = set_c_im;
      end else begin
         zr = 0;
         zi = 0;
         cr = pr;
         ci = pim;
      end
      n = 0;
      while (radius_sq(zr, zi) <= FOUR_WIDE && n < set_limit) begin
         sq = zr * zr - zi * zi;
         twice_re_im = zr * zi;
         if (set_mode == MODE_SHIP && twice_re_im < 0) twice_re_im = -twice_re_im;
         nr = clamp_q((sq >>> 24) + cr);
         ni = clamp_q((twice_re_im >>> 23) + ci);
         zr = nr;
         zi = ni;
         n++;
      end
      res.x     = px;
      res.y     = py;
      res.iters = n[ITER_W-1:0];
      res.esc   = radius_sq(zr, zi) > FOUR_WIDE;
      return res;
   endfunction

   function automatic int pick_gap(input int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0 || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   function automatic int rand_span(input int span);
      int v;
      v = $urandom_range(0, 2 * span);
      return v - span;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // driver: one request at a time from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (drain_hold && n_sent == n_recv) drain_hold = 1'b0;
         if (send_gap > 0 || drain_hold || pending_pixels.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            next_pixel = pending_pixels.pop_front();
            req_valid   <= 1'b1;
            req_pixel_x <= next_pixel.x;
            req_pixel_y <= next_pixel.y;
            launched++;
            send_gap = pick_gap(send_calm);
            if (launched == 100 || $urandom_range(0, 49) == 0) drain_hold = 1'b1;
         end
         if (send_calm > 0) send_calm--;
         else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(20, 150);
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (ready_hold == 0 && $urandom_range(0, 5) == 0) ready_hold = pick_gap(ready_calm);
         rsp_ready <= (ready_hold == 0);
         if (ready_hold > 0) ready_hold--;
         if (ready_calm > 0) ready_calm--;
         else if ($urandom_range(0, 299) == 0) ready_calm = $urandom_range(50, 300);
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pixel_outcomes.size());
         $display("status: fail");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pixel_outcomes.push_back(evaluate_pixel(req_pixel_x, req_pixel_y));
            n_sent <= n_sent + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_outcomes.size() == 0) begin
               report_mismatch($sformatf("response (%0d,%0d) with no request pending",
                                         rsp_out_x, rsp_out_y));
            end else begin
               want = pixel_outcomes.pop_front();
               n_recv <= n_recv + 1;
               if (want.esc) escaped_count++;
               else capped_count++;
               if (rsp_out_x !== want.x)
                  report_mismatch($sformatf("out_x %0d, want %0d", rsp_out_x, want.x));
               if (rsp_out_y !== want.y)
                  report_mismatch($sformatf("out_y %0d, want %0d", rsp_out_y, want.y));
               if (rsp_iterations !== want.iters)
                  report_mismatch($sformatf("pixel (%0d,%0d) iterations %0d, want %0d",
                                            want.x, want.y, rsp_iterations, want.iters));
               if (rsp_escaped !== want.esc)
                  report_mismatch($sformatf("pixel (%0d,%0d) escaped %0b, want %0b",
                                            want.x, want.y, rsp_escaped, want.esc));
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [Q_W-1:0] value);
      logic [Q_W-1:0] word;
      word = value;
      if (idx == CSR_MODE) word = ($urandom() << MODE_W) | value[MODE_W-1:0];
      if (idx == CSR_MAX_ITER) word = ($urandom() << ITER_W) | value[ITER_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= word;
      case (idx)
         CSR_MODE:     set_mode   = word[MODE_W-1:0];
         CSR_MAX_ITER: set_limit  = word[ITER_W-1:0];
         CSR_STEP_X:   set_step_x = int'(word);
         CSR_STEP_Y:   set_step_y = int'(word);
         CSR_OFFSET_X: set_pan_x  = int'(word);
         CSR_OFFSET_Y: set_pan_y  = int'(word);
         CSR_JULIA_RE: set_c_re   = int'(word);
         CSR_JULIA_IM: set_c_im   = int'(word);
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [MODE_W-1:0] m, input logic [ITER_W-1:0] lim,
                                 input int sx, input int sy, input int ox, input int oy,
                                 input int jr, input int ji);
      write_reg(CSR_MODE, Q_W'(m));
      write_reg(CSR_MAX_ITER, Q_W'(lim));
      write_reg(CSR_STEP_X, sx);
      write_reg(CSR_STEP_Y, sy);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Y, oy);
      write_reg(CSR_JULIA_RE, jr);
      write_reg(CSR_JULIA_IM, ji);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic queue_pixel(input int x, input int y);
      pixel_req_t p;
      p.x = x[PIX_W-1:0];
      p.y = y[PIX_W-1:0];
      pending_pixels.push_back(p);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (!(pending_pixels.size() == 0 && !req_valid && n_sent == n_recv));
   endtask

   task automatic run_random_phase(input int p);
      logic [MODE_W-1:0] m;
      logic [ITER_W-1:0] lim;
      int sx, sy, ox, oy, jr, ji, count, r;
      r = $urandom_range(0, 9);
      m = (r < 3) ? MODE_MANDEL : (r < 6) ? MODE_JULIA : (r < 9) ? MODE_SHIP : MODE_SPARE;
      sx = $urandom_range(2000, 160000);
      sy = $urandom_range(2000, 160000);
      if ($urandom_range(0, 1)) sx = -sx;
      if ($urandom_range(0, 1)) sy = -sy;
      ox = rand_span(2 * Q_ONE);
      oy = rand_span(2 * Q_ONE);
      jr = rand_span(3 * Q_ONE / 2);
      ji = rand_span(3 * Q_ONE / 2);
      count = 50;
      if ($urandom_range(0, 3) == 0) lim = ITER_W'($urandom_range(65, 200));
      else lim = ITER_W'($urandom_range(1, 64));
      if (p == 0) begin
         lim = 10'd1023;
         count = 6;
      end else if (p == 1) begin
         lim = 10'd1;
         count = 40;
      end else if (p == 2) begin
         sx = int'($urandom());
         sy = int'($urandom());
         ox = int'($urandom());
         oy = int'($urandom());
         jr = int'($urandom());
         ji = int'($urandom());
         count = 40;
      end
      apply_settings(m, lim, sx, sy, ox, oy, jr, ji);
      for (int i = 0; i < count; i++)
         queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      wait_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: center point stays bounded, corners leave
      queue_pixel(512, 512);
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(0, 1023);
      queue_pixel(1023, 0);
      queue_pixel(300, 700);
      wait_idle();

      // Julia: a start point already outside gives zero updates
      apply_settings(MODE_JULIA, 10'd32, 81920, 81920, 0, 0, RST_JULIA_RE, RST_JULIA_IM);
      queue_pixel(512, 512);
      queue_pixel(0, 0);
      queue_pixel(1023, 512);
      queue_pixel(600, 400);
      wait_idle();

      apply_settings(MODE_SHIP, 10'd64, 81920, 81920, -(Q_ONE / 2), -(Q_ONE / 2), 0, 0);
      queue_pixel(0, 0);
      queue_pixel(512, 512);
      queue_pixel(1023, 1023);
      queue_pixel(400, 300);
      queue_pixel(700, 200);
      wait_idle();

      // unused mode code behaves as Mandelbrot
      apply_settings(MODE_SPARE, 10'd20, 81920, 81920, -(Q_ONE / 2), 0, 0, 0);
      queue_pixel(512, 512);
      queue_pixel(100, 900);
      wait_idle();

      // zero limit, no update at all
      apply_settings(MODE_MANDEL, 10'd0, 81920, 81920, 0, 0, 0, 0);
      queue_pixel(0, 0);
      wait_idle();
      apply_settings(MODE_JULIA, 10'd0, 81920, 81920, 0, 0, RST_JULIA_RE, RST_JULIA_IM);
      queue_pixel(0, 0);
      queue_pixel(512, 512);
      wait_idle();

      // saturating pixel mapping at the register extremes
      apply_settings(MODE_MANDEL, 10'd8, int'(32'h7FFFFFFF), int'(32'h80000000),
                     int'(32'h7FFFFFFF), int'(32'h80000000), 0, 0);
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(512, 512);
      queue_pixel(513, 511);
      wait_idle();

      // saturating z update with an extreme Julia constant
      apply_settings(MODE_JULIA, 10'd4, 4096, 4096, 0, 0, int'(32'h7FFFFFFF),
                     int'(32'h80000000));
      queue_pixel(512, 512);
      queue_pixel(520, 505);
      wait_idle();

      for (int p = 0; p < 12; p++) run_random_phase(p);

      repeat (16) @(posedge clock);
      if (pixel_outcomes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pixel_outcomes.size()));
      $display("checked %0d pixels under %0d register settings (all modes, limits 0 to 1023)",
               n_recv, settings_count + 1);
      $display("%0d pixels escaped, %0d ran to the limit, %0d mismatches",
               escaped_count, capped_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
